[rtl/core/mlp_pkg.sv]
// ----------------------------------------------------------------------------
// mlp_pkg
// shared sizes, fixed-point constants and control types of the 6-6-1
// perceptron core
// ----------------------------------------------------------------------------
package mlp_pkg;

   // network shape
   localparam int FEATURES    = 6;
   localparam int HIDDEN      = 6;
   localparam int IN_FEATURES = 6;
   localparam int NEURON_SPAN = FEATURES + 1;
   localparam int OUT_BASE    = HIDDEN * NEURON_SPAN;
   localparam int STORE_DEPTH = OUT_BASE + HIDDEN + 1;
   localparam int MAX_SPAN    = ((FEATURES > HIDDEN) ? FEATURES : HIDDEN) + 1;

   // widths
   localparam int DATA_W = 16;
   localparam int PROD_W = 2 * DATA_W;
   localparam int ACC_W  = 40;
   localparam int ADDR_W = $clog2(STORE_DEPTH);
   localparam int TERM_W = $clog2(MAX_SPAN);
   localparam int NEUR_W = $clog2(HIDDEN + 1);

   // fixed-point conversion Q20.20 -> Q8.8
   localparam int FRAC_SHIFT = 12;
   localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(2048);
   localparam logic signed [ACC_W-1:0] Q_MAX_ACC  = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] Q_MIN_ACC  = -ACC_W'(32768);
   localparam logic signed [DATA_W-1:0] Q_MAX = 16'sh7fff;
   localparam logic signed [DATA_W-1:0] Q_MIN = 16'sh8000;

   // a bias term is the bias weight times 1.0 in Q8.8
   localparam logic signed [DATA_W-1:0] BIAS_SCALE = 16'sd256;

   // request kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_INFER = 1'b1;

   // one term entering the multiply-accumulate unit
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic out_layer;
   } mac_ctrl_type;

   // one finished neuron leaving the unit
   typedef struct packed {
      logic                     done;
      logic                     out_layer;
      logic signed [DATA_W-1:0] value;
      logic                     clipped;
   } mac_res_type;

endpackage

[rtl/core/mlp_weight_ram.sv]
// ----------------------------------------------------------------------------
// mlp_weight_ram
// weight and bias store, one write port and one registered read port
// ----------------------------------------------------------------------------
module mlp_weight_ram
   import mlp_pkg::*;
(
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  logic signed [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]        rd_addr,
   output logic signed [DATA_W-1:0] rd_data
);

   logic signed [DATA_W-1:0] mem [STORE_DEPTH];
   logic signed [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/mlp_mac.sv]
// ----------------------------------------------------------------------------
// mlp_mac
// shared multiply-accumulate unit with rounding, relu and saturation to Q8.8
// ----------------------------------------------------------------------------
module mlp_mac
   import mlp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  mac_ctrl_type             ctrl,
   input  logic signed [DATA_W-1:0] weight,
   input  logic signed [DATA_W-1:0] operand,
   output mac_res_type              res
);

   logic signed [PROD_W-1:0] prod_ff;
   logic                     prod_valid_ff;
   logic                     prod_first_ff;
   logic                     prod_last_ff;
   logic                     prod_out_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  prod_ext;
   logic                     done_ff;
   logic                     done_out_ff;
   logic signed [ACC_W-1:0]  rounded;
   logic signed [ACC_W-1:0]  scaled;

   // product stage
   always_ff @(posedge clock) begin
      prod_ff       <= weight * operand;
      prod_first_ff <= ctrl.first;
      prod_last_ff  <= ctrl.last;
      prod_out_ff   <= ctrl.out_layer;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= ctrl.valid;
      end
   end

   // accumulate stage
   assign prod_ext = ACC_W'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      if (prod_valid_ff) begin
         acc_in = prod_first_ff ? prod_ext : acc_ff + prod_ext;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      done_out_ff <= prod_out_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= prod_valid_ff && prod_last_ff;
      end
   end

   // round half up and clip to Q8.8, relu for hidden neurons
   assign rounded = acc_ff + ROUND_BIAS;
   assign scaled  = rounded >>> FRAC_SHIFT;

   always_comb begin
      res.done      = done_ff;
      res.out_layer = done_out_ff;
      res.value     = scaled[DATA_W-1:0];
      res.clipped   = 1'b0;
      if (!done_out_ff && acc_ff <= ACC_W'(0)) begin
         res.value = '0;
      end else if (scaled > Q_MAX_ACC) begin
         res.value   = Q_MAX;
         res.clipped = 1'b1;
      end else if (done_out_ff && scaled < Q_MIN_ACC) begin
         res.value   = Q_MIN;
         res.clipped = 1'b1;
      end
   end

endmodule

[rtl/core/mlp_inference_six_six_one.sv]
// requests: a new request is taken only while the sequencer is idle, so inferences do not overlap;
//   their pace is set by the single multiply-accumulate unit taking one weight per cycle
//   from the one read port of the weight store
// stalls: a response still held by rsp_stall holds the next one in its last step
// reset: sequencer idle and response channel empty; the weight store is not cleared
// ----------------------------------------------------------------------------
// mlp_inference_six_six_one
// fully connected 6-6-1 perceptron, weights loaded by request, one shared
// multiply-accumulate unit walked through the store by a small sequencer
// ----------------------------------------------------------------------------
module mlp_inference_six_six_one
   import mlp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_type,
   input  logic [5:0]               req_weight_index,
   input  logic signed [DATA_W-1:0] req_weight_value,
   input  logic signed [DATA_W-1:0] req_feature_0,
   input  logic signed [DATA_W-1:0] req_feature_1,
   input  logic signed [DATA_W-1:0] req_feature_2,
   input  logic signed [DATA_W-1:0] req_feature_3,
   input  logic signed [DATA_W-1:0] req_feature_4,
   input  logic signed [DATA_W-1:0] req_feature_5,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_prediction,
   output logic                     rsp_saturated
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_HID_RUN  = 3'd1;
   localparam logic [2:0] S_DRAIN    = 3'd2;
   localparam logic [2:0] S_OUT_RUN  = 3'd3;
   localparam logic [2:0] S_OUT_WAIT = 3'd4;
   localparam logic [2:0] S_RESP     = 3'd5;

   logic [2:0]               state_ff, state_in;
   logic [ADDR_W-1:0]        addr_ff, addr_in;
   logic [TERM_W-1:0]        term_ff, term_in;
   logic [NEUR_W-1:0]        neur_ff, neur_in;
   logic                     drain_ff, drain_in;
   logic [NEUR_W-1:0]        hid_wr_ff, hid_wr_in;
   logic                     clip_ff, clip_in;
   logic signed [DATA_W-1:0] pred_ff, pred_in;
   logic signed [DATA_W-1:0] feat_ff [FEATURES];
   logic signed [DATA_W-1:0] hid_ff [HIDDEN];
   logic signed [DATA_W-1:0] in_feat [IN_FEATURES];

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_prediction_ff;
   logic                     rsp_saturated_ff;
   logic                     rsp_load;

   logic                     s1_valid_ff;
   logic                     s1_first_ff;
   logic                     s1_last_ff;
   logic                     s1_out_ff;
   logic [TERM_W-1:0]        s1_term_ff;

   logic                     req_accept;
   logic                     issue;
   logic                     term_last;
   logic                     ram_wr_en;
   logic signed [DATA_W-1:0] ram_rd_data;
   logic signed [DATA_W-1:0] operand;
   mac_ctrl_type             mac_ctrl;
   mac_res_type              mac_res;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);

   assign in_feat[0] = req_feature_0;
   assign in_feat[1] = req_feature_1;
   assign in_feat[2] = req_feature_2;
   assign in_feat[3] = req_feature_3;
   assign in_feat[4] = req_feature_4;
   assign in_feat[5] = req_feature_5;

   // weight store, writes beyond the store are dropped
   assign ram_wr_en = req_accept && (req_type == REQ_WRITE)
                      && (int'(req_weight_index) < STORE_DEPTH);

   mlp_weight_ram u_weight_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ADDR_W'(req_weight_index)),
      .wr_data (req_weight_value),
      .rd_addr (addr_ff),
      .rd_data (ram_rd_data)
   );

   // term position within the current neuron
   assign issue     = (state_ff == S_HID_RUN) || (state_ff == S_OUT_RUN);
   assign term_last = (state_ff == S_OUT_RUN) ? (term_ff == TERM_W'(HIDDEN))
                                              : (term_ff == TERM_W'(FEATURES));

   // sequencer
   always_comb begin
      state_in  = state_ff;
      addr_in   = addr_ff;
      term_in   = term_ff;
      neur_in   = neur_ff;
      drain_in  = drain_ff;
      hid_wr_in = hid_wr_ff;
      clip_in   = clip_ff;
      pred_in   = pred_ff;
      rsp_load  = 1'b0;

      if (mac_res.done && !mac_res.out_layer) begin
         hid_wr_in = hid_wr_ff + 1'b1;
         clip_in   = clip_ff | mac_res.clipped;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept && req_type == REQ_INFER) begin
               state_in  = S_HID_RUN;
               addr_in   = '0;
               term_in   = '0;
               neur_in   = '0;
               hid_wr_in = '0;
               clip_in   = 1'b0;
            end
         end
         S_HID_RUN: begin
            addr_in = addr_ff + 1'b1;
            if (term_last) begin
               term_in = '0;
               if (neur_ff == NEUR_W'(HIDDEN - 1)) begin
                  state_in = S_DRAIN;
                  drain_in = 1'b0;
               end else begin
                  neur_in = neur_ff + 1'b1;
               end
            end else begin
               term_in = term_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            // let the last hidden neuron settle before its value is used
            drain_in = 1'b1;
            if (drain_ff) begin
               state_in = S_OUT_RUN;
            end
         end
         S_OUT_RUN: begin
            addr_in = addr_ff + 1'b1;
            if (term_last) begin
               state_in = S_OUT_WAIT;
            end else begin
               term_in = term_ff + 1'b1;
            end
         end
         S_OUT_WAIT: begin
            if (mac_res.done && mac_res.out_layer) begin
               pred_in  = mac_res.value;
               clip_in  = clip_ff | mac_res.clipped;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      term_ff   <= term_in;
      neur_ff   <= neur_in;
      drain_ff  <= drain_in;
      hid_wr_ff <= hid_wr_in;
      clip_ff   <= clip_in;
      pred_ff   <= pred_in;
   end

   // feature latch, features past the sixth read as zero
   always_ff @(posedge clock) begin
      if (req_accept && req_type == REQ_INFER) begin
         for (int k = 0; k < FEATURES; k++) begin
            feat_ff[k] <= (k < IN_FEATURES) ? in_feat[k] : '0;
         end
      end
   end

   // hidden values, written in neuron order
   always_ff @(posedge clock) begin
      if (mac_res.done && !mac_res.out_layer) begin
         for (int k = 0; k < HIDDEN; k++) begin
            if (hid_wr_ff == NEUR_W'(k)) begin
               hid_ff[k] <= mac_res.value;
            end
         end
      end
   end

   // term tags aligned with the store read data
   always_ff @(posedge clock) begin
      s1_first_ff <= (term_ff == '0);
      s1_last_ff  <= term_last;
      s1_out_ff   <= (state_ff == S_OUT_RUN);
      s1_term_ff  <= term_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
      end
   end

   // operand select: bias scale, feature or hidden value
   always_comb begin
      operand = '0;
      if (s1_last_ff) begin
         operand = BIAS_SCALE;
      end else if (s1_out_ff) begin
         for (int k = 0; k < HIDDEN; k++) begin
            if (s1_term_ff == TERM_W'(k)) begin
               operand = hid_ff[k];
            end
         end
      end else begin
         for (int k = 0; k < FEATURES; k++) begin
            if (s1_term_ff == TERM_W'(k)) begin
               operand = feat_ff[k];
            end
         end
      end
   end

   assign mac_ctrl.valid     = s1_valid_ff;
   assign mac_ctrl.first     = s1_first_ff;
   assign mac_ctrl.last      = s1_last_ff;
   assign mac_ctrl.out_layer = s1_out_ff;

   mlp_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mac_ctrl),
      .weight  (ram_rd_data),
      .operand (operand),
      .res     (mac_res)
   );

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_prediction_ff <= pred_ff;
         rsp_saturated_ff  <= clip_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_prediction = rsp_prediction_ff;
   assign rsp_saturated  = rsp_saturated_ff;

`ifndef SYNTHESIS
   // the output neuron only finishes while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      (mac_res.done && mac_res.out_layer) |-> (state_ff == S_OUT_WAIT))
      else $error("output neuron finished outside the wait state");

   // no hidden neuron finishes once all hidden slots are filled
   assert property (@(posedge clock) disable iff (reset)
      (mac_res.done && !mac_res.out_layer) |-> (hid_wr_ff < NEUR_W'(HIDDEN)))
      else $error("hidden neuron finished beyond the hidden count");

   // reads stay within the store
   assert property (@(posedge clock) disable iff (reset)
      issue |-> (int'(addr_ff) < STORE_DEPTH))
      else $error("store read beyond the last entry");

   // every hidden value is in place by the time a response is ready
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && $past(state_ff) != S_RESP)
      |-> (hid_wr_ff == NEUR_W'(HIDDEN)))
      else $error("response ready before all hidden neurons finished");
`endif

endmodule

[tb/tb_mlp_inference_six_six_one.sv]
// ----------------------------------------------------------------------------
// tb_mlp_inference_six_six_one
// self-checking bench for the 6-6-1 perceptron core: loads weight sets by
// request, runs directed corner inferences and random mixed traffic under
// several idle and stall mixes, and compares every response in order against
// a fixed-point prediction of the network kept inside the bench
// ----------------------------------------------------------------------------
module tb_mlp_inference_six_six_one;
   timeunit 1ns;
   timeprecision 1ps;
   import mlp_pkg::*;

   localparam int CYCLE_LIMIT      = 400000;
   localparam int LONG_HOLD        = 300;
   localparam int DRAIN_CYCLES     = 64;
   localparam int ITEMS_PER_PHASE  = 40;
   localparam int BURST_ITEMS      = 10;
   localparam logic [DATA_W-1:0] ONE_Q412 = 16'sd4096;

   typedef logic [IN_FEATURES-1:0][DATA_W-1:0] feature_vec_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] prediction;
      logic                     saturated;
   } network_answer_type;

   // weight set shapes used to steer the network into its corners
   typedef enum int {
      NET_SMALL,
      NET_FULL,
      NET_PASS,
      NET_HIDDEN_CLIP,
      NET_NEG_OUT,
      NET_ROUND
   } net_shape_type;

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_stall;
   logic                     req_type         = REQ_WRITE;
   logic [5:0]               req_weight_index = '0;
   logic signed [DATA_W-1:0] req_weight_value = '0;
   logic signed [DATA_W-1:0] req_feature_0    = '0;
   logic signed [DATA_W-1:0] req_feature_1    = '0;
   logic signed [DATA_W-1:0] req_feature_2    = '0;
   logic signed [DATA_W-1:0] req_feature_3    = '0;
   logic signed [DATA_W-1:0] req_feature_4    = '0;
   logic signed [DATA_W-1:0] req_feature_5    = '0;
   logic                     rsp_valid;
   logic                     rsp_stall        = 1'b0;
   logic signed [DATA_W-1:0] rsp_prediction;
   logic                     rsp_saturated;

   logic signed [DATA_W-1:0] weight_mirror [STORE_DEPTH];
   network_answer_type       pending_answers [$];
   int                       error_count  = 0;
   int                       cycle_count  = 0;
   int                       send_idle_pct = 0;
   int                       stall_pct     = 0;
   int                       hold_left     = 0;

   mlp_inference_six_six_one dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_weight_index (req_weight_index),
      .req_weight_value (req_weight_value),
      .req_feature_0    (req_feature_0),
      .req_feature_1    (req_feature_1),
      .req_feature_2    (req_feature_2),
      .req_feature_3    (req_feature_3),
      .req_feature_4    (req_feature_4),
      .req_feature_5    (req_feature_5),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_prediction   (rsp_prediction),
      .rsp_saturated    (rsp_saturated)
   );

   // clock, 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_mlp_inference_six_six_one: errors");
         $finish;
      end
   end

   // fixed-point evaluation of the network from the mirrored weights
   function automatic network_answer_type predict_network(input feature_vec_type feats);
      network_answer_type res;
      longint             acc;
      longint             v;
      longint             hid [HIDDEN];
      longint             x;
      int                 base;
      bit                 clip;
      clip = 1'b0;
      for (int n = 0; n < HIDDEN; n++) begin
         base = n * NEURON_SPAN;
         acc  = longint'(weight_mirror[base + FEATURES]) * 256;
         for (int j = 0; j < FEATURES; j++) begin
            x = 0;
            if (j < IN_FEATURES) x = longint'($signed(feats[j]));
            acc += longint'(weight_mirror[base + j]) * x;
         end
         // relu, then round half up and clip the top
         if (acc <= 0) begin
            hid[n] = 0;
         end else begin
            v = (acc + 2048) >>> FRAC_SHIFT;
            if (v > 32767) begin
               v    = 32767;
               clip = 1'b1;
            end
            hid[n] = v;
         end
      end
      acc = longint'(weight_mirror[OUT_BASE + HIDDEN]) * 256;
      for (int j = 0; j < HIDDEN; j++)
         acc += longint'(weight_mirror[OUT_BASE + j]) * hid[j];
      v = (acc + 2048) >>> FRAC_SHIFT;
      if (v > 32767) begin
         v    = 32767;
         clip = 1'b1;
      end else if (v < -32768) begin
         v    = -32768;
         clip = 1'b1;
      end
      res.prediction = DATA_W'(v);
      res.saturated  = clip;
      return res;
   endfunction

   // receiver: random stall, or a long hold-off while hold_left counts down
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // response checking, then request tracking, in one process
   always @(posedge clock) begin
      network_answer_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               $error("response with no inference request outstanding");
               error_count++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_prediction !== want.prediction) begin
                  $error("prediction: expected %0d, actual %0d",
                         want.prediction, rsp_prediction);
                  error_count++;
               end
               if (rsp_saturated !== want.saturated) begin
                  $error("saturated: expected %0d, actual %0d",
                         want.saturated, rsp_saturated);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_type == REQ_WRITE) begin
               // writes past the store are dropped
               if (req_weight_index < STORE_DEPTH)
                  weight_mirror[req_weight_index] = req_weight_value;
            end else begin
               pending_answers.push_back(predict_network({req_feature_5, req_feature_4,
                  req_feature_3, req_feature_2, req_feature_1, req_feature_0}));
            end
         end
      end
   end

   // offer one request, sometimes after a random idle gap, and wait for acceptance
   task automatic send_request(input logic kind, input logic [5:0] index,
                               input logic [DATA_W-1:0] value,
                               input feature_vec_type feats);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid        <= 1'b1;
      req_type         <= kind;
      req_weight_index <= index;
      req_weight_value <= value;
      req_feature_0    <= feats[0];
      req_feature_1    <= feats[1];
      req_feature_2    <= feats[2];
      req_feature_3    <= feats[3];
      req_feature_4    <= feats[4];
      req_feature_5    <= feats[5];
      do @(posedge clock); while (req_stall);
   endtask

   function automatic feature_vec_type random_features();
      feature_vec_type f;
      for (int j = 0; j < IN_FEATURES; j++) begin
         case ($urandom_range(3))
            0: f[j] = DATA_W'($urandom_range(2047)) - 16'sd1024;
            1: f[j] = DATA_W'($urandom_range(255)) - 16'sd128;
            2: begin
               case ($urandom_range(3))
                  0: f[j] = 16'sh7fff;
                  1: f[j] = 16'sh8000;
                  2: f[j] = 16'sh0000;
                  default: f[j] = 16'shffff;
               endcase
            end
            default: f[j] = DATA_W'($urandom);
         endcase
      end
      return f;
   endfunction

   task automatic write_weight(input logic [5:0] index, input logic [DATA_W-1:0] value);
      send_request(REQ_WRITE, index, value, random_features());
   endtask

   task automatic run_inference(input feature_vec_type feats);
      send_request(REQ_INFER, 6'($urandom), DATA_W'($urandom), feats);
   endtask

   function automatic logic [DATA_W-1:0] shape_weight(input net_shape_type shape,
                                                      input int idx);
      int  n;
      int  j;
      bit  hidden;
      hidden = (idx < OUT_BASE);
      n      = idx / NEURON_SPAN;
      j      = hidden ? idx % NEURON_SPAN : idx - OUT_BASE;
      case (shape)
         NET_SMALL: return DATA_W'($urandom_range(8191)) - ONE_Q412;
         NET_FULL:  return DATA_W'($urandom);
         // hidden n copies feature n, output sums the hidden layer
         NET_PASS: begin
            if (hidden) return (j == n) ? ONE_Q412 : '0;
            return (j < HIDDEN) ? ONE_Q412 : '0;
         end
         // every hidden weight at its maximum, gentle output layer
         NET_HIDDEN_CLIP: begin
            if (hidden) return 16'sh7fff;
            return (j < HIDDEN) ? 16'sd16 : '0;
         end
         // copy features, then a strongly negative output layer
         NET_NEG_OUT: begin
            if (hidden) return (j == n) ? ONE_Q412 : '0;
            return 16'sh8000;
         end
         // tiny weight on feature 0 and an output bias of minus half an lsb
         default: begin
            if (hidden) return (n == 0 && j == 0) ? 16'sd1 : '0;
            if (j == 0) return ONE_Q412;
            return (j == HIDDEN) ? -16'sd8 : '0;
         end
      endcase
   endfunction

   task automatic load_network(input net_shape_type shape);
      for (int i = 0; i < STORE_DEPTH; i++)
         write_weight(6'(i), shape_weight(shape, i));
   endtask

   // first fill of the store, then writes beyond it that must be dropped
   task automatic test_store_load();
      load_network(NET_PASS);
      write_weight(6'(STORE_DEPTH), 16'sh7fff);
      write_weight(6'd63, 16'sh8000);
      write_weight(6'(STORE_DEPTH + 5), 16'sh5a5a);
      run_inference({IN_FEATURES{16'sh0100}});
      run_inference({16'sh0600, 16'sh0500, 16'sh0400, 16'sh0300, 16'sh0200, 16'sh0100});
   endtask

   // field extremes, relu, both clips and half-lsb rounding
   task automatic test_corner_cases();
      run_inference('0);
      run_inference({IN_FEATURES{16'sh7fff}});
      run_inference({IN_FEATURES{16'sh8000}});
      run_inference({16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
      run_inference({IN_FEATURES{16'shffff}});
      load_network(NET_HIDDEN_CLIP);
      run_inference({IN_FEATURES{16'sh7fff}});
      run_inference({IN_FEATURES{16'sh8000}});
      run_inference('0);
      load_network(NET_NEG_OUT);
      run_inference({IN_FEATURES{16'sh7fff}});
      run_inference('0);
      run_inference({IN_FEATURES{16'sh8000}});
      load_network(NET_ROUND);
      run_inference({80'h0, 16'sh07ff});
      run_inference({80'h0, 16'sh0800});
      run_inference({80'h0, 16'sh1800});
      run_inference('0);
      run_inference({IN_FEATURES{16'shffff}});
      load_network(NET_FULL);
      run_inference({IN_FEATURES{16'sh7fff}});
      run_inference({IN_FEATURES{16'sh8000}});
   endtask

   // mixed random traffic with one idle and stall mix
   task automatic test_random_traffic(input int idle_pct, input int stall_in);
      net_shape_type shape;
      int            count;
      int            pick;
      send_idle_pct = idle_pct;
      stall_pct     = stall_in;
      shape = ($urandom_range(1) == 0) ? NET_SMALL : NET_FULL;
      count = 0;
      while (count < ITEMS_PER_PHASE) begin
         pick = $urandom_range(99);
         if (pick < 20) begin
            write_weight(6'($urandom_range(STORE_DEPTH - 1)), shape_weight(shape, 0));
            count++;
         end else if (pick < 24) begin
            // dropped write, not counted
            write_weight(6'($urandom_range(63, STORE_DEPTH)), DATA_W'($urandom));
         end else begin
            run_inference(random_features());
            count++;
         end
      end
   endtask

   // long receiver hold-off while the sender keeps offering inferences
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_left    <= LONG_HOLD;
      for (int i = 0; i < BURST_ITEMS; i++)
         run_inference(random_features());
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_store_load();
      test_corner_cases();
      load_network(NET_SMALL);
      test_random_traffic(0, 0);
      test_random_traffic(45, 0);
      test_random_traffic(0, 45);
      test_random_traffic(22, 22);
      test_backpressure();
      test_random_traffic(0, 0);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb_mlp_inference_six_six_one: clean");
      else
         $display("tb_mlp_inference_six_six_one: errors");
      $finish;
   end

endmodule
